### design/assert_macros.svh
// Assertion helper macros used by the decode top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/tswd_pkg.sv
// ----------------------------------------------------------------------------
// Trellis weight decode package
// Constants and types shared by the decode pipeline.
// ----------------------------------------------------------------------------
package tswd_pkg;

    localparam logic [31:0] MUL_CONST = 32'd89226354;
    localparam logic [31:0] ADD_CONST = 32'd64248484;
    localparam logic [31:0] AND_MASK  = 32'h8FFF_8FFF;
    localparam logic [31:0] XOR_MASK  = 32'h3B60_3B60;

    // Signed operand or sum in units of 2^-13; |sum| < 2^15.
    typedef logic signed [15:0] t_units;

    // Magnitude and sign after the add stage.
    typedef struct packed {
        logic        sign;
        logic [14:0] mag;
    } t_summag;

    // Decode a masked fp16 operand (exponent 12..15) into units.
    function automatic t_units half_to_units(input logic [15:0] h);
        logic [1:0]  sh;
        logic [14:0] mag;
        sh  = h[11:10];
        mag = {4'd0, 1'b1, h[9:0]} << sh;
        return h[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

### design/tswd_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one 16-bit word.
// ----------------------------------------------------------------------------
interface tswd_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/trellis_state_weight_decode_top.sv
// ----------------------------------------------------------------------------
// Trellis state weight decode
// Decodes one 16-bit trellis state into one fp16 weight per cycle when not stalled.
// ----------------------------------------------------------------------------
// One word enters per cycle unless stalled; the stages are the multiply, mask
// and unpack, add, leading-one and round register stages, plus the output
// register. The whole pipeline advances whenever its output register is
// empty or being taken, and halts as one while a waiting word is not taken.
module trellis_state_weight_decode_top
    import tswd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tswd_if.sink   s_in,
    tswd_if.source m_out
);
`include "assert_macros.svh"

    logic        w_en;
    logic        w_hv, w_rv;
    t_units      w_a, w_b;
    logic [15:0] w_half;
    logic        r_ov;
    logic [15:0] r_od;

    // Advance when the output register can take a word
    assign w_en       = !r_ov || m_out.ready;
    assign s_in.ready = w_en;

    tswd_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(s_in.valid), .i_state(s_in.data),
        .o_valid(w_hv), .o_a(w_a), .o_b(w_b)
    );

    tswd_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_hv), .i_a(w_a), .i_b(w_b),
        .o_valid(w_rv), .o_half(w_half)
    );

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_rv;
        end
        if (w_en) begin
            r_od <= w_half;
        end
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_od;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready, m_out.valid && $stable(m_out.data))
    `ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !m_out.valid, s_in.ready)
    `ASSERT_IMPL(a_exp, i_clk, i_rst_n, m_out.valid && (m_out.data[14:0] != 15'd0), m_out.data[14:10] != 5'd31)

endmodule

### design/tswd_hash.sv
// ----------------------------------------------------------------------------
// State hash stage
// Multiply-add of the state, then mask and unpack into two operand units.
// ----------------------------------------------------------------------------
module tswd_hash
    import tswd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [15:0] i_state,
    output logic        o_valid,
    output t_units      o_a,
    output t_units      o_b
);

    logic        r_v1, r_v2;
    logic [31:0] r_prod;
    t_units      r_a, r_b;
    logic [31:0] n_w;

    // Mask the hashed word
    always_comb begin
        n_w = ((r_prod + ADD_CONST) & AND_MASK) ^ XOR_MASK;
    end

    // Advance the two hash stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_prod <= {16'd0, i_state} * MUL_CONST;
            r_a    <= half_to_units(n_w[15:0]);
            r_b    <= half_to_units(n_w[31:16]);
        end
    end

    assign o_valid = r_v2;
    assign o_a     = r_a;
    assign o_b     = r_b;

endmodule

### design/tswd_round.sv
// ----------------------------------------------------------------------------
// Add and round stages
// Sum the operands, find the leading one, round to fp16 nearest-even.
// ----------------------------------------------------------------------------
module tswd_round
    import tswd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_units      i_a,
    input  t_units      i_b,
    output logic        o_valid,
    output logic [15:0] o_half
);

    logic        r_v1, r_v2, r_v3;
    t_summag     r_sm;
    logic        r_sign, r_zero;
    logic [3:0]  r_p;
    logic [14:0] r_mag;
    logic [15:0] r_half;
    t_units      n_sum;
    logic [3:0]  n_p;
    logic [15:0] n_half;
    logic [14:0] n_norm;
    logic [11:0] n_sig;
    logic [4:0]  n_exp;
    logic        n_lsb, n_rnd, n_stk;

    // Sum the operands; the add stage register takes the magnitude
    always_comb begin
        n_sum = i_a + i_b;
    end

    // Find the leading one position
    always_comb begin
        n_p = 4'd0;
        for (int k = 0; k < 15; k++) begin
            if (r_sm.mag[k]) n_p = 4'(k);
        end
    end

    // Round to nearest even; p ranges 0..14, so the left shift is 0..14
    always_comb begin
        n_norm = r_mag << (4'd14 - r_p);
        n_lsb  = n_norm[4];
        n_rnd  = n_norm[3];
        n_stk  = |n_norm[2:0];
        n_sig  = {1'b0, n_norm[14:4]} + {11'd0, n_rnd & (n_stk | n_lsb)};
        n_exp  = 5'({1'b0, r_p} + 5'd2);
        if (n_sig[11]) begin
            n_exp = n_exp + 5'd1;
        end
        n_half = {r_sign, n_exp, n_sig[11] ? 10'd0 : n_sig[9:0]};
        if (r_zero) n_half = 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_sm.sign <= n_sum[15];
            r_sm.mag  <= n_sum[15] ? 15'(-n_sum) : n_sum[14:0];
            r_sign    <= r_sm.sign;
            r_zero    <= (r_sm.mag == 15'd0);
            r_p       <= n_p;
            r_mag     <= r_sm.mag;
            r_half    <= n_half;
        end
    end

    assign o_valid = r_v3;
    assign o_half  = r_half;

endmodule

### tb/trellis_state_weight_decode_checker.sv
// ----------------------------------------------------------------------------
// Trellis weight decode checker
// Watches both channels, works out the expected fp16 weight for every state
// word taken in, and compares it with every weight word given out.
// ----------------------------------------------------------------------------
module trellis_state_weight_decode_checker
    import tswd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_weights_seen
);

    logic [15:0] weights_due[$];

    // Turn a masked fp16 operand into a signed count of 2^-13 steps.
    function automatic int operand_steps(input logic [15:0] h);
        int mag;
        mag = int'({1'b1, h[9:0]}) << (int'(h[14:10]) - 12);
        return h[15] ? -mag : mag;
    endfunction

    // Round a signed count of 2^-13 steps to fp16, ties to even.
    function automatic logic [15:0] steps_to_half(input int v);
        logic        neg;
        int unsigned mag, sig, rem, halfway;
        int          msb, sh;
        if (v == 0) begin
            return 16'h0000;
        end
        neg = v < 0;
        mag = neg ? -v : v;
        msb = 0;
        while ((mag >> (msb + 1)) != 0) begin
            msb++;
        end
        if (msb <= 10) begin
            sig = mag << (10 - msb);
        end else begin
            sh      = msb - 10;
            sig     = mag >> sh;
            rem     = mag & ((32'd1 << sh) - 1);
            halfway = 32'd1 << (sh - 1);
            if (rem > halfway || (rem == halfway && sig[0])) begin
                sig++;
            end
            if (sig == 32'h800) begin
                sig = 32'h400;
                msb++;
            end
        end
        return {neg, 5'(msb + 2), sig[9:0]};
    endfunction

    // Hash the state, mask it, and add its two halves.
    function automatic logic [15:0] decode_weight(input logic [15:0] state);
        logic [31:0] w;
        w = (({16'd0, state} * MUL_CONST + ADD_CONST) & AND_MASK) ^ XOR_MASK;
        return steps_to_half(operand_steps(w[15:0]) + operand_steps(w[31:16]));
    endfunction

    assign o_pending = weights_due.size();

    // Predict on every taken state word; compare every taken weight word.
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            o_fail_count   <= 0;
            o_weights_seen <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                weights_due.push_back(decode_weight(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                o_weights_seen <= o_weights_seen + 1;
                if (weights_due.size() == 0) begin
                    $error("weight_half: unexpected word, expected none, actual %h",
                           i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = weights_due.pop_front();
                    if (want !== i_out_data) begin
                        $error("weight_half: expected %h, actual %h", want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/trellis_state_weight_decode_top_tb.sv
// ----------------------------------------------------------------------------
// Trellis weight decode testbench
// Streams directed and random state words through the decoder with random
// gaps and stalls on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module trellis_state_weight_decode_top_tb;

    localparam int RANDOM_WORDS = 700;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   weights_seen;
    int   words_sent;
    bit   hold_off_long;
    bit   stimulus_done;
    bit   drained;

    tswd_if s_in ();
    tswd_if m_out ();

    trellis_state_weight_decode_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out)
    );

    trellis_state_weight_decode_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_in.valid),
        .i_in_ready     (s_in.ready),
        .i_in_data      (s_in.data),
        .i_out_valid    (m_out.valid),
        .i_out_ready    (m_out.ready),
        .i_out_data     (m_out.data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_weights_seen (weights_seen)
    );

    // Run the clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Offer one state word and hold it until taken, after a random gap unless no_gap is set.
    task automatic send_word(input logic [15:0] state, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
        if (gap > 0) begin
            s_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data  <= state;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Make stimulus
    initial begin
        logic [15:0] directed[$];
        int          burst;
        s_in.valid     = 1'b0;
        s_in.data      = '0;
        i_rst_n        = 1'b0;
        words_sent     = 0;
        hold_off_long  = 1'b0;
        stimulus_done  = 1'b0;
        drained        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Field extremes, single even bits and complements of single odd bits
        directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
        for (int b = 0; b < 16; b += 2) begin
            directed.push_back(16'(1 << b));
            directed.push_back(~16'(2 << b));
        end
        foreach (directed[k]) send_word(directed[k], 1'b0);

        // Fill the pipe while the receiver holds off
        hold_off_long = 1'b1;
        for (int k = 0; k < 24; k++) send_word(16'($urandom), 1'b1);
        s_in.valid <= 1'b0;
        wait (hold_off_long == 1'b0);

        // Random words, in back-to-back bursts and sparse runs; pause once for drain
        while (words_sent < RANDOM_WORDS + 46) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                send_word(16'($urandom), 1'($urandom_range(0, 1)));
            end
            if (words_sent > 300 && !drained) begin
                drained = 1'b1;
                s_in.valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
        end
        s_in.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Stall the receiver at random, with one long hold-off
    initial begin
        m_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_long) begin
                m_out.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off_long = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                m_out.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            m_out.ready <= 1'b1;
        end
    end

    // Give the verdict once everything has drained
    initial begin
        wait (stimulus_done);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Decoded %0d state words into %0d weights under random gaps and stalls.",
                 words_sent, weights_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #200000;
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tswd_pkg.sv
design/tswd_if.sv
design/tswd_hash.sv
design/tswd_round.sv
design/trellis_state_weight_decode_top.sv
tb/trellis_state_weight_decode_checker.sv
tb/trellis_state_weight_decode_top_tb.sv
